### rtl/pctu_pkg.sv
// ----------------------------------------------------------------------------
// pctu_pkg
// Shared field widths, command codes and register indexes for the canvas
// blitter with undo journal.
// ----------------------------------------------------------------------------
package pctu_pkg;

	localparam int MODE_W    = 4;
	localparam int POS_W     = 6;
	localparam int SIZE_W    = 7;
	localparam int CLR_W     = 4;
	localparam int CNT_OUT_W = 13;
	localparam int REG_IDX_W = 2;
	localparam int REG_W     = 7;
	localparam int OPAQUE_BIT = 3;

	localparam int DEF_CANVAS_SIDE   = 64;
	localparam int DEF_JOURNAL_DEPTH = 4096;
	localparam int DEF_COLOR_BITS    = 4;

	localparam logic [REG_W-1:0] RESET_ACTIVE = 7'd64;

	localparam logic [MODE_W-1:0] MODE_READ      = 4'd0;
	localparam logic [MODE_W-1:0] MODE_WRITE     = 4'd1;
	localparam logic [MODE_W-1:0] MODE_BLIT      = 4'd2;
	localparam logic [MODE_W-1:0] MODE_ROTATE    = 4'd3;
	localparam logic [MODE_W-1:0] MODE_FLIP_ROWS = 4'd4;
	localparam logic [MODE_W-1:0] MODE_FLIP_COLS = 4'd5;
	localparam logic [MODE_W-1:0] MODE_MIRROR    = 4'd6;
	localparam logic [MODE_W-1:0] MODE_CLEAR     = 4'd7;
	localparam logic [MODE_W-1:0] MODE_UNDO      = 4'd8;

	localparam logic [REG_IDX_W-1:0] REG_ACTIVE_WIDTH  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_ACTIVE_HEIGHT = 2'd1;

endpackage

### rtl/pctu_ram.sv
// ----------------------------------------------------------------------------
// pctu_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pctu_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/pixel_canvas_transform_undo.sv
// ----------------------------------------------------------------------------
// pixel_canvas_transform_undo
// Indexed-color canvas with pixel, blit and region commands and an undo journal.
// ----------------------------------------------------------------------------
// One command is taken at a time; its result is registered, so the next command
// can be taken while the result waits. Rotate, flip and mirror first copy the
// canvas into a snapshot RAM, then walk the region pixel by pixel, writing the
// pixels that land inside the canvas and the active area and dropping the rest;
// clear walks every canvas pixel the same way. Undo restores the last ungrouped
// entry, or the last group back to its head. After reset a clearing pass zeroes
// the canvas before the first command is taken; register writes are taken
// during that pass.
// ----------------------------------------------------------------------------
module pixel_canvas_transform_undo import pctu_pkg::*; #(
	parameter int CANVAS_SIDE   = DEF_CANVAS_SIDE,
	parameter int JOURNAL_DEPTH = DEF_JOURNAL_DEPTH,
	parameter int COLOR_BITS    = DEF_COLOR_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [MODE_W-1:0]    mode,
	input  logic [POS_W-1:0]     pos_x,
	input  logic [POS_W-1:0]     pos_y,
	input  logic [SIZE_W-1:0]    region_width,
	input  logic [SIZE_W-1:0]    region_height,
	input  logic [CLR_W-1:0]     pixel_color,
	input  logic                 overwrite,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [CLR_W-1:0]     read_color,
	output logic [CNT_OUT_W-1:0] journal_used,
	output logic [CNT_OUT_W-1:0] restored_count,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_data
);

	localparam int CELLS = CANVAS_SIDE * CANVAS_SIDE;
	localparam int AW    = $clog2(CELLS);
	localparam int KW    = $clog2(CELLS + 1);
	localparam int CW    = $clog2(CANVAS_SIDE);
	localparam int JAW   = $clog2(JOURNAL_DEPTH);
	localparam int JCW   = $clog2(JOURNAL_DEPTH + 1);
	localparam int OCW   = (JCW > CNT_OUT_W) ? JCW : CNT_OUT_W;
	localparam int EW    = COLOR_BITS + 2 * CW + 2;
	localparam int LW    = ($clog2(CANVAS_SIDE + 1) > SIZE_W) ? $clog2(CANVAS_SIDE + 1) : SIZE_W;
	localparam int SW    = LW + 1;

	localparam logic [3:0] ST_CLR  = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_RDA  = 4'd2;
	localparam logic [3:0] ST_RDB  = 4'd3;
	localparam logic [3:0] ST_CP   = 4'd4;
	localparam logic [3:0] ST_PA   = 4'd5;
	localparam logic [3:0] ST_PB   = 4'd6;
	localparam logic [3:0] ST_UA   = 4'd7;
	localparam logic [3:0] ST_UB   = 4'd8;
	localparam logic [3:0] ST_DONE = 4'd9;

	logic [3:0]        state_q;
	logic [MODE_W-1:0] mode_q;
	logic [POS_W-1:0]  x_q, y_q;
	logic [SIZE_W-1:0] w_q, h_q;
	logic [CLR_W-1:0]  color_q;
	logic [LW-1:0]     ni_q, nj_q, i_q, j_q, s_q;
	logic [KW-1:0]     k_q;
	logic [REG_W-1:0]  aw_q, ah_q;
	logic [JAW-1:0]    top_q;
	logic [JCW-1:0]    jcount_q, restored_q;
	logic              head_done_q, grouped_q;
	logic              src_ok_s1;
	logic [AW-1:0]     dst_addr_s1;
	logic [CW-1:0]     dx_s1, dy_s1;
	logic [CLR_W-1:0]  rd_color_q;
	logic              out_valid_q;
	logic [CLR_W-1:0]  read_color_q;
	logic [CNT_OUT_W-1:0] used_q, restored_out_q;

	// memory ports
	logic                  cv_we, sp_we, jr_we;
	logic [AW-1:0]         cv_waddr, cv_raddr, sp_waddr, sp_raddr;
	logic [COLOR_BITS-1:0] cv_wdata, cv_rdata, sp_rdata;
	logic [JAW-1:0]        jr_raddr;
	logic [EW-1:0]         jr_wdata, jr_rdata;

	pctu_ram #(.WIDTH(COLOR_BITS), .DEPTH(CELLS)) u_canvas (
		.clk(clk), .we(cv_we), .waddr(cv_waddr), .wdata(cv_wdata),
		.raddr(cv_raddr), .rdata(cv_rdata)
	);

	pctu_ram #(.WIDTH(COLOR_BITS), .DEPTH(CELLS)) u_snap (
		.clk(clk), .we(sp_we), .waddr(sp_waddr), .wdata(cv_rdata),
		.raddr(sp_raddr), .rdata(sp_rdata)
	);

	pctu_ram #(.WIDTH(EW), .DEPTH(JOURNAL_DEPTH)) u_journal (
		.clk(clk), .we(jr_we), .waddr(top_q), .wdata(jr_wdata),
		.raddr(jr_raddr), .rdata(jr_rdata)
	);

	// pixel walk geometry
	logic [SW-1:0]         xe, ye, ie, je, dx, dy, sx, sy;
	logic                  dst_ok, src_ok, last_j, last_i;
	logic [AW-1:0]         dst_addr, src_addr;
	logic [COLOR_BITS-1:0] new_val;
	logic                  is_region;
	logic [JAW-1:0]        top_inc, top_dec;
	logic [LW-1:0]         in_w, in_h, in_s, in_ni, in_nj;
	logic [3:0]            in_next;

	always_comb begin
		xe = SW'(x_q);
		ye = SW'(y_q);
		ie = SW'(i_q);
		je = SW'(j_q);
		sx = xe + je;
		sy = ye + ie;
		case (mode_q) inside
			MODE_ROTATE: begin
				dx = xe + SW'(s_q) - SW'(1) - ie;
				dy = ye + je;
			end
			MODE_FLIP_ROWS: begin
				dx = xe + je;
				dy = ye + SW'(h_q) - SW'(1) - ie;
			end
			MODE_FLIP_COLS, MODE_MIRROR: begin
				dx = xe + SW'(w_q) - SW'(1) - je;
				dy = ye + ie;
			end
			MODE_CLEAR: begin
				dx = je;
				dy = ie;
			end
			default: begin
				dx = xe;
				dy = ye;
			end
		endcase
		dst_ok = (dx < SW'(CANVAS_SIDE)) && (dy < SW'(CANVAS_SIDE))
			&& (dx < SW'(aw_q)) && (dy < SW'(ah_q));
		src_ok = (sx < SW'(CANVAS_SIDE)) && (sy < SW'(CANVAS_SIDE));
		dst_addr = AW'(32'(dy) * 32'(CANVAS_SIDE) + 32'(dx));
		src_addr = AW'(32'(sy) * 32'(CANVAS_SIDE) + 32'(sx));
		last_j = (j_q + LW'(1)) == nj_q;
		last_i = (i_q + LW'(1)) == ni_q;
		is_region = (mode_q == MODE_ROTATE) || (mode_q == MODE_FLIP_ROWS)
			|| (mode_q == MODE_FLIP_COLS) || (mode_q == MODE_MIRROR);
		if (is_region) begin
			new_val = src_ok_s1 ? sp_rdata : '0;
		end else if (mode_q == MODE_CLEAR) begin
			new_val = '0;
		end else begin
			new_val = COLOR_BITS'(color_q);
		end
		top_inc = (top_q == JAW'(JOURNAL_DEPTH - 1)) ? '0 : top_q + JAW'(1);
		top_dec = (top_q == '0) ? JAW'(JOURNAL_DEPTH - 1) : top_q - JAW'(1);
	end

	// command decode at accept
	always_comb begin
		in_w  = LW'(region_width);
		in_h  = LW'(region_height);
		in_s  = (in_w < in_h) ? in_w : in_h;
		in_ni = '0;
		in_nj = '0;
		unique case (mode) inside
			MODE_READ: in_next = ST_RDA;
			MODE_WRITE: begin
				in_ni = LW'(1);
				in_nj = LW'(1);
				in_next = ST_PA;
			end
			MODE_BLIT: begin
				in_ni = LW'(1);
				in_nj = LW'(1);
				in_next = (overwrite || pixel_color[OPAQUE_BIT]) ? ST_PA : ST_DONE;
			end
			MODE_ROTATE: begin
				in_ni = in_s;
				in_nj = in_s;
				in_next = (in_s == '0) ? ST_DONE : ST_CP;
			end
			MODE_FLIP_ROWS, MODE_FLIP_COLS: begin
				in_ni = in_h;
				in_nj = in_w;
				in_next = (in_h == '0 || in_w == '0) ? ST_DONE : ST_CP;
			end
			MODE_MIRROR: begin
				in_ni = in_h;
				in_nj = in_w >> 1;
				in_next = (in_h == '0 || (in_w >> 1) == '0) ? ST_DONE : ST_CP;
			end
			MODE_CLEAR: begin
				in_ni = LW'(CANVAS_SIDE);
				in_nj = LW'(CANVAS_SIDE);
				in_next = ST_PA;
			end
			MODE_UNDO: in_next = ST_UA;
			default: in_next = ST_DONE;
		endcase
	end

	// memory port steering
	always_comb begin
		cv_we    = 1'b0;
		cv_waddr = dst_addr_s1;
		cv_wdata = new_val;
		cv_raddr = dst_addr;
		sp_we    = 1'b0;
		sp_waddr = AW'(k_q - KW'(1));
		sp_raddr = src_addr;
		jr_we    = 1'b0;
		jr_wdata = {grouped_q && !head_done_q, grouped_q, dy_s1, dx_s1, cv_rdata};
		jr_raddr = top_dec;
		case (state_q)
			ST_CLR: begin
				cv_we    = 1'b1;
				cv_waddr = k_q[AW-1:0];
				cv_wdata = '0;
			end
			ST_RDA: cv_raddr = AW'(32'(y_q) * 32'(CANVAS_SIDE) + 32'(x_q));
			ST_CP: begin
				cv_raddr = k_q[AW-1:0];
				sp_we    = (k_q != '0);
			end
			ST_PB: begin
				cv_we = (cv_rdata != new_val);
				jr_we = (cv_rdata != new_val);
			end
			ST_UB: begin
				cv_we    = 1'b1;
				cv_waddr = AW'(32'(jr_rdata[COLOR_BITS+CW +: CW]) * 32'(CANVAS_SIDE)
					+ 32'(jr_rdata[COLOR_BITS +: CW]));
				cv_wdata = jr_rdata[COLOR_BITS-1:0];
			end
			default: ;
		endcase
	end

	logic [OCW-1:0] used_ext, rest_ext;
	assign used_ext = OCW'(jcount_q);
	assign rest_ext = OCW'(restored_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			k_q         <= '0;
			aw_q        <= RESET_ACTIVE;
			ah_q        <= RESET_ACTIVE;
			top_q       <= '0;
			jcount_q    <= '0;
			head_done_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == REG_ACTIVE_WIDTH) aw_q <= cfg_data;
				if (cfg_index == REG_ACTIVE_HEIGHT) ah_q <= cfg_data;
			end
			if (state_q == ST_DONE && (!out_valid_q || out_ready)) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;

			unique case (state_q)
				ST_CLR: begin
					if (k_q == KW'(CELLS - 1)) begin
						k_q     <= '0;
						state_q <= ST_IDLE;
					end else begin
						k_q <= k_q + KW'(1);
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						mode_q      <= mode;
						x_q         <= pos_x;
						y_q         <= pos_y;
						w_q         <= region_width;
						h_q         <= region_height;
						color_q     <= pixel_color;
						s_q         <= in_s;
						ni_q        <= in_ni;
						nj_q        <= in_nj;
						i_q         <= '0;
						j_q         <= '0;
						k_q         <= '0;
						grouped_q   <= (mode == MODE_ROTATE) || (mode == MODE_FLIP_ROWS)
							|| (mode == MODE_FLIP_COLS) || (mode == MODE_MIRROR)
							|| (mode == MODE_CLEAR);
						head_done_q <= 1'b0;
						restored_q  <= '0;
						rd_color_q  <= '0;
						state_q     <= in_next;
					end
				end
				ST_RDA: begin
					src_ok_s1 <= (32'(x_q) < CANVAS_SIDE) && (32'(y_q) < CANVAS_SIDE);
					state_q   <= ST_RDB;
				end
				ST_RDB: begin
					rd_color_q <= src_ok_s1 ? cv_rdata[CLR_W-1:0] : '0;
					state_q    <= ST_DONE;
				end
				ST_CP: begin
					// read one cell ahead, write the previous one into the snapshot
					if (k_q == KW'(CELLS)) begin
						k_q     <= '0;
						state_q <= ST_PA;
					end else begin
						k_q <= k_q + KW'(1);
					end
				end
				ST_PA: begin
					if (dst_ok) begin
						src_ok_s1   <= src_ok;
						dst_addr_s1 <= dst_addr;
						dx_s1       <= dx[CW-1:0];
						dy_s1       <= dy[CW-1:0];
						state_q     <= ST_PB;
					end else if (last_j) begin
						j_q <= '0;
						if (last_i) state_q <= ST_DONE;
						else i_q <= i_q + LW'(1);
					end else begin
						j_q <= j_q + LW'(1);
					end
				end
				ST_PB: begin
					if (cv_rdata != new_val) begin
						top_q <= top_inc;
						if (jcount_q != JCW'(JOURNAL_DEPTH)) jcount_q <= jcount_q + JCW'(1);
						if (grouped_q) head_done_q <= 1'b1;
					end
					if (last_j) begin
						j_q <= '0;
						if (last_i) state_q <= ST_DONE;
						else begin
							i_q     <= i_q + LW'(1);
							state_q <= ST_PA;
						end
					end else begin
						j_q     <= j_q + LW'(1);
						state_q <= ST_PA;
					end
				end
				ST_UA: begin
					if (jcount_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						top_q      <= top_dec;
						jcount_q   <= jcount_q - JCW'(1);
						restored_q <= restored_q + JCW'(1);
						state_q    <= ST_UB;
					end
				end
				ST_UB: begin
					// stop on an ungrouped entry or on the head of a group
					if (!jr_rdata[EW-2] || jr_rdata[EW-1]) state_q <= ST_DONE;
					else state_q <= ST_UA;
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						read_color_q   <= rd_color_q;
						used_q         <= used_ext[CNT_OUT_W-1:0];
						restored_out_q <= rest_ext[CNT_OUT_W-1:0];
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready       = (state_q == ST_IDLE);
	assign cfg_ready      = 1'b1;
	assign out_valid      = out_valid_q;
	assign read_color     = read_color_q;
	assign journal_used   = used_q;
	assign restored_count = restored_out_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		jcount_q <= JCW'(JOURNAL_DEPTH))
		else $error("journal count above depth");

	a_no_write_in_copy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CP) |-> !cv_we)
		else $error("canvas written during snapshot copy");

	a_push_counts: assert property (@(posedge clk) disable iff (!arst_n)
		jr_we |=> (jcount_q == $past(jcount_q) + JCW'(1))
			|| ($past(jcount_q) == JCW'(JOURNAL_DEPTH)))
		else $error("journal push without count update");

	a_done_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && (!out_valid_q || out_ready)) |=> out_valid_q)
		else $error("finished request not presented");
`endif

endmodule

### sim/tb_pixel_canvas_transform_undo.sv
// ----------------------------------------------------------------------------
// tb_pixel_canvas_transform_undo
// Self-checking bench for the canvas blitter with undo journal. A directed
// table (typed results where obvious) is followed by random command phases at
// several active-area settings. Untyped results are compared against an in-bench
// canvas/journal predictor. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_pixel_canvas_transform_undo;
	import pctu_pkg::*;

	localparam int SIDE  = DEF_CANVAS_SIDE;
	localparam int CELLS = SIDE * SIDE;
	localparam int JDEPTH = DEF_JOURNAL_DEPTH;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [POS_W-1:0]  x;
		logic [POS_W-1:0]  y;
		logic [SIZE_W-1:0] w;
		logic [SIZE_W-1:0] h;
		logic [CLR_W-1:0]  color;
		logic              ow;
	} cmd_t;

	typedef struct packed {
		logic [CLR_W-1:0]     rd;
		logic [CNT_OUT_W-1:0] used;
		logic [CNT_OUT_W-1:0] restored;
	} res_t;

	typedef struct packed {
		cmd_t c;
		logic typed;
		res_t r;
	} row_t;

	typedef struct {
		logic [CLR_W-1:0] old;
		int               x;
		int               y;
		bit               grp;
		bit               head;
	} jent_t;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [MODE_W-1:0] mode;
	logic [POS_W-1:0] pos_x, pos_y;
	logic [SIZE_W-1:0] region_width, region_height;
	logic [CLR_W-1:0] pixel_color;
	logic overwrite;
	logic [CLR_W-1:0] read_color;
	logic [CNT_OUT_W-1:0] journal_used, restored_count;
	logic cfg_valid, cfg_ready;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [REG_W-1:0] cfg_data;

	pixel_canvas_transform_undo u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .pos_x(pos_x), .pos_y(pos_y),
		.region_width(region_width), .region_height(region_height),
		.pixel_color(pixel_color), .overwrite(overwrite),
		.out_valid(out_valid), .out_ready(out_ready),
		.read_color(read_color), .journal_used(journal_used),
		.restored_count(restored_count),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor state
	logic [CLR_W-1:0] pix[CELLS];
	logic [CLR_W-1:0] pix_snap[CELLS];
	jent_t jrnl[JDEPTH];
	int jrnl_top, jrnl_cnt;
	bit head_done;
	int act_w, act_h;

	res_t expected_q[$];
	int mismatches;
	int burst_left;
	int stall_phase;

	function automatic logic [CLR_W-1:0] snap_at(int x, int y);
		if (x >= SIDE || y >= SIDE)
			return '0;
		return pix_snap[y * SIDE + x];
	endfunction

	function automatic void put_pixel(int x, int y, logic [CLR_W-1:0] color, bit grp);
		int idx;
		if (x >= SIDE || y >= SIDE || x >= act_w || y >= act_h)
			return;
		idx = y * SIDE + x;
		if (pix[idx] == color)
			return;
		jrnl[jrnl_top].old = pix[idx];
		jrnl[jrnl_top].x = x;
		jrnl[jrnl_top].y = y;
		jrnl[jrnl_top].grp = grp;
		jrnl[jrnl_top].head = grp && !head_done;
		if (grp)
			head_done = 1;
		jrnl_top = (jrnl_top + 1) % JDEPTH;
		if (jrnl_cnt < JDEPTH)
			jrnl_cnt++;
		pix[idx] = color;
	endfunction

	function automatic void take_snapshot();
		pix_snap = pix;
		head_done = 0;
	endfunction

	function automatic int undo_last();
		int n;
		jent_t e;
		n = 0;
		while (jrnl_cnt > 0) begin
			jrnl_top = (jrnl_top + JDEPTH - 1) % JDEPTH;
			e = jrnl[jrnl_top];
			jrnl_cnt--;
			pix[e.y * SIDE + e.x] = e.old;
			n++;
			if (!e.grp || e.head)
				break;
		end
		return n;
	endfunction

	function automatic res_t canvas_step(cmd_t c);
		res_t r;
		int x, y, w, h, s;
		x = c.x; y = c.y; w = c.w; h = c.h;
		r = '0;
		case (c.mode)
			MODE_READ: r.rd = pix[y * SIDE + x];
			MODE_WRITE: put_pixel(x, y, c.color, 0);
			MODE_BLIT: begin
				if (c.ow || c.color[OPAQUE_BIT])
					put_pixel(x, y, c.color, 0);
			end
			MODE_ROTATE: begin
				s = (w < h) ? w : h;
				take_snapshot();
				for (int i = 0; i < s; i++)
					for (int j = 0; j < s; j++)
						put_pixel(x + s - 1 - i, y + j, snap_at(x + j, y + i), 1);
			end
			MODE_FLIP_ROWS: begin
				take_snapshot();
				for (int i = 0; i < h; i++)
					for (int j = 0; j < w; j++)
						put_pixel(x + j, y + h - 1 - i, snap_at(x + j, y + i), 1);
			end
			MODE_FLIP_COLS: begin
				take_snapshot();
				for (int i = 0; i < h; i++)
					for (int j = 0; j < w; j++)
						put_pixel(x + w - 1 - j, y + i, snap_at(x + j, y + i), 1);
			end
			MODE_MIRROR: begin
				take_snapshot();
				for (int i = 0; i < h; i++)
					for (int j = 0; j < w / 2; j++)
						put_pixel(x + w - 1 - j, y + i, snap_at(x + j, y + i), 1);
			end
			MODE_CLEAR: begin
				take_snapshot();
				for (int i = 0; i < SIDE; i++)
					for (int j = 0; j < SIDE; j++)
						put_pixel(j, i, '0, 1);
			end
			MODE_UNDO: r.restored = CNT_OUT_W'(undo_last());
			default: ;
		endcase
		r.used = CNT_OUT_W'(jrnl_cnt);
		return r;
	endfunction

	function automatic logic [SIZE_W-1:0] rand_size();
		return ($urandom_range(0, 9) == 0) ? SIZE_W'(SIDE) : SIZE_W'($urandom_range(0, 8));
	endfunction

	function automatic cmd_t rand_cmd();
		cmd_t c;
		int pick;
		c.x = POS_W'($urandom); c.y = POS_W'($urandom);
		c.w = rand_size(); c.h = rand_size();
		c.color = CLR_W'($urandom); c.ow = 1'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 20)      c.mode = MODE_READ;
		else if (pick < 40) c.mode = MODE_WRITE;
		else if (pick < 55) c.mode = MODE_BLIT;
		else if (pick < 60) c.mode = MODE_ROTATE;
		else if (pick < 65) c.mode = MODE_FLIP_ROWS;
		else if (pick < 70) c.mode = MODE_FLIP_COLS;
		else if (pick < 75) c.mode = MODE_MIRROR;
		else if (pick < 77) c.mode = MODE_CLEAR;
		else if (pick < 95) c.mode = MODE_UNDO;
		else                c.mode = MODE_W'($urandom_range(9, 15));
		return c;
	endfunction

	// one request, sent in bursts with random gaps
	task automatic send_cmd(cmd_t c, logic typed, res_t typed_res);
		int gap;
		res_t pred;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 8);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b1;
		mode <= c.mode; pos_x <= c.x; pos_y <= c.y;
		region_width <= c.w; region_height <= c.h;
		pixel_color <= c.color; overwrite <= c.ow;
		do @(posedge clk); while (!in_ready);
		pred = canvas_step(c);
		expected_q.push_back(typed ? typed_res : pred);
		burst_left--;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		burst_left = 0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// leaves cfg_valid high; the caller drops it after the last write
	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [REG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_ACTIVE_WIDTH)
			act_w = int'(data);
		else
			act_h = int'(data);
	endtask

	task automatic set_area(logic [REG_W-1:0] w, logic [REG_W-1:0] h);
		write_reg(REG_ACTIVE_WIDTH, w);
		write_reg(REG_ACTIVE_HEIGHT, h);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// receiver: long always-ready stretches, otherwise random stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_phase <= 0;
		end else begin
			stall_phase <= stall_phase + 1;
			if (stall_phase[8:7] == 2'd0)
				out_ready <= 1'b1;
			else
				out_ready <= ($urandom_range(0, 2) != 0);
		end
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result rd=%0d used=%0d restored=%0d",
						read_color, journal_used, restored_count);
			end else begin
				want = expected_q[0];
				expected_q.delete(0);
				if (read_color !== want.rd || journal_used !== want.used ||
					restored_count !== want.restored) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: exp rd=%0d used=%0d restored=%0d, ",
							"got rd=%0d used=%0d restored=%0d"},
							want.rd, want.used, want.restored,
							read_color, journal_used, restored_count);
				end
			end
		end
	end

	row_t dir_rows[20];

	initial begin
		int areas_w[6];
		int areas_h[6];
		res_t none;
		none = '0;
		// mode, x, y, w, h, color, ow | typed | rd, used, restored
		dir_rows[0]  = '{'{MODE_READ, 6'd0, 6'd0, 7'd0, 7'd0, 4'd0, 1'b0}, 1'b1, '{4'd0, 13'd0, 13'd0}};
		dir_rows[1]  = '{'{MODE_UNDO, 6'd0, 6'd0, 7'd0, 7'd0, 4'd0, 1'b0}, 1'b1, '{4'd0, 13'd0, 13'd0}};
		dir_rows[2]  = '{'{MODE_WRITE, 6'd63, 6'd63, 7'd0, 7'd0, 4'd15, 1'b0}, 1'b1, '{4'd0, 13'd1, 13'd0}};
		dir_rows[3]  = '{'{MODE_READ, 6'd63, 6'd63, 7'd0, 7'd0, 4'd0, 1'b0}, 1'b1, '{4'd15, 13'd1, 13'd0}};
		// same color again: nothing journaled
		dir_rows[4]  = '{'{MODE_WRITE, 6'd63, 6'd63, 7'd0, 7'd0, 4'd15, 1'b0}, 1'b1, '{4'd0, 13'd1, 13'd0}};
		// transparent blit
		dir_rows[5]  = '{'{MODE_BLIT, 6'd0, 6'd0, 7'd0, 7'd0, 4'd7, 1'b0}, 1'b1, '{4'd0, 13'd1, 13'd0}};
		dir_rows[6]  = '{'{MODE_BLIT, 6'd0, 6'd0, 7'd0, 7'd0, 4'd7, 1'b1}, 1'b1, '{4'd0, 13'd2, 13'd0}};
		dir_rows[7]  = '{'{MODE_BLIT, 6'd1, 6'd0, 7'd0, 7'd0, 4'd8, 1'b0}, 1'b1, '{4'd0, 13'd3, 13'd0}};
		dir_rows[8]  = '{'{MODE_UNDO, 6'd0, 6'd0, 7'd0, 7'd0, 4'd0, 1'b0}, 1'b1, '{4'd0, 13'd2, 13'd1}};
		dir_rows[9]  = '{'{MODE_ROTATE, 6'd0, 6'd0, 7'd64, 7'd3, 4'd0, 1'b0}, 1'b0, none};
		// region hanging off the canvas
		dir_rows[10] = '{'{MODE_FLIP_ROWS, 6'd60, 6'd60, 7'd64, 7'd64, 4'd0, 1'b0}, 1'b0, none};
		dir_rows[11] = '{'{MODE_FLIP_COLS, 6'd0, 6'd0, 7'd5, 7'd7, 4'd0, 1'b0}, 1'b0, none};
		dir_rows[12] = '{'{MODE_MIRROR, 6'd0, 6'd0, 7'd9, 7'd4, 4'd0, 1'b0}, 1'b0, none};
		dir_rows[13] = '{'{MODE_ROTATE, 6'd5, 6'd5, 7'd0, 7'd9, 4'd0, 1'b0}, 1'b0, none};
		dir_rows[14] = '{'{MODE_UNDO, 6'd0, 6'd0, 7'd0, 7'd0, 4'd0, 1'b0}, 1'b0, none};
		dir_rows[15] = '{'{MODE_CLEAR, 6'd0, 6'd0, 7'd0, 7'd0, 4'd0, 1'b0}, 1'b0, none};
		dir_rows[16] = '{'{MODE_UNDO, 6'd0, 6'd0, 7'd0, 7'd0, 4'd0, 1'b0}, 1'b0, none};
		dir_rows[17] = '{'{4'd9, 6'd42, 6'd21, 7'd85, 7'd42, 4'd5, 1'b1}, 1'b0, none};
		dir_rows[18] = '{'{4'd15, 6'd63, 6'd63, 7'd127, 7'd127, 4'd15, 1'b1}, 1'b0, none};
		dir_rows[19] = '{'{MODE_READ, 6'd1, 6'd0, 7'd0, 7'd0, 4'd0, 1'b0}, 1'b0, none};

		areas_w = '{40, 1, 64, 0, 127, 64};
		areas_h = '{23, 64, 1, 127, 0, 64};

		arst_n <= 1'b0;
		in_valid <= 1'b0; cfg_valid <= 1'b0;
		mode <= '0; pos_x <= '0; pos_y <= '0;
		region_width <= '0; region_height <= '0;
		pixel_color <= '0; overwrite <= 1'b0;
		cfg_index <= '0; cfg_data <= '0;
		for (int i = 0; i < CELLS; i++) begin
			pix[i] = '0;
			pix_snap[i] = '0;
		end
		jrnl_top = 0; jrnl_cnt = 0; head_done = 0;
		act_w = int'(RESET_ACTIVE); act_h = int'(RESET_ACTIVE);
		mismatches = 0; burst_left = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_area(7'd64, 7'd64);
		foreach (dir_rows[i])
			send_cmd(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].r);

		for (int p = 0; p < 6; p++) begin
			wait_idle();
			set_area(REG_W'(areas_w[p]), REG_W'(areas_h[p]));
			for (int n = 0; n < 20; n++)
				send_cmd(rand_cmd(), 1'b0, none);
		end

		wait_idle();
		if (mismatches == 0 && expected_q.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#500000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

### pixel_canvas_transform_undo.f
rtl/pctu_pkg.sv
rtl/pctu_ram.sv
rtl/pixel_canvas_transform_undo.sv
sim/tb_pixel_canvas_transform_undo.sv
